### rtl/wrpq_pkg.sv
package wrpq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_e;

endpackage

### rtl/wrpq_if.sv
interface wrpq_req_if #(
  parameter int WEIGHT_BITS = 16,
  parameter int VALUE_BITS  = 32,
  parameter int DRAW_BITS   = 16
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [WEIGHT_BITS-1:0] weight;
  logic [VALUE_BITS-1:0]  item_value;
  logic [DRAW_BITS-1:0]   random_draw;

  modport source (output valid, action, weight, item_value, random_draw, input ready);
  modport sink   (input valid, action, weight, item_value, random_draw, output ready);
endinterface

interface wrpq_rsp_if #(
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS   = 5
);
  logic                  valid;
  logic                  ready;
  wrpq_pkg::status_e     status;
  logic [VALUE_BITS-1:0] popped_value;
  logic [CNT_BITS-1:0]   entry_count;
  logic                  is_empty;

  modport source (output valid, status, popped_value, entry_count, is_empty, input ready);
  modport sink   (input valid, status, popped_value, entry_count, is_empty, output ready);
endinterface

### rtl/wrpq_mul.sv
module wrpq_mul #(
  parameter int A_BITS = 20,
  parameter int B_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [A_BITS-1:0]        a_i,
  input  logic [B_BITS-1:0]        b_i,
  output logic                     done_o,
  output logic [A_BITS+B_BITS-1:0] prod_o
);
  import wrpq_pkg::*;

  localparam int CntW = (B_BITS > 1) ? $clog2(B_BITS) : 1;

  logic                     run_q, done_q;
  logic [CntW-1:0]          cnt_q;
  logic [A_BITS-1:0]        a_q;
  logic [B_BITS-1:0]        b_q;
  logic [A_BITS+B_BITS-1:0] acc_q;

  // Shift-and-add, most significant multiplier bit first, one bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(B_BITS - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= (acc_q << 1) + (b_q[B_BITS-1] ? (A_BITS+B_BITS)'(a_q) : '0);
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/weighted_random_pick_queue_core.sv
// Insert, pop on an empty table and insert on a full table go straight to the done state; the
// result is loaded into the output register once it is free. Pop: the serial multiply (one
// draw bit per cycle), the scan up to the chosen slot and the move of the last slot come first.
// One request is in flight at a time; the next is accepted at the edge after the result is
// loaded into the output register, even while that result waits.
// Reset clears occupancy, the weight total and all control state; slot memory is not cleared.
module weighted_random_pick_queue_core #(
  parameter int DEPTH       = 16,
  parameter int VALUE_BITS  = 32,
  parameter int WEIGHT_BITS = 16,
  parameter int DRAW_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrpq_req_if.sink   req_i,
  wrpq_rsp_if.source rsp_o
);
  import wrpq_pkg::*;

  localparam int IdxW  = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int TotW  = WEIGHT_BITS + IdxW;
  localparam int SlotW = VALUE_BITS + WEIGHT_BITS;

  // Slot memory: each word holds {value, weight}, one synchronous read port.
  logic [SlotW-1:0] slot_mem [DEPTH];
  logic [SlotW-1:0] rd_data_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [SlotW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= slot_mem[mem_raddr];
  end

  state_e           state_q, state_d;
  logic [CntW-1:0]  occ_q;
  logic [TotW-1:0]  total_q;
  logic [TotW-1:0]  run_q;
  logic [IdxW-1:0]  dat_idx_q, pick_idx_q, last_idx;
  logic [VALUE_BITS-1:0]  pick_val_q;
  logic [WEIGHT_BITS-1:0] pick_w_q;
  status_e          res_status_q;
  logic [VALUE_BITS-1:0]  res_popped_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [VALUE_BITS-1:0]  out_popped_q;
  logic [CntW-1:0]  out_count_q;

  logic             in_fire, is_full, is_empty_now, out_free;
  logic             mul_start, mul_done;
  logic [TotW+DRAW_BITS-1:0] mul_prod;
  logic [TotW-1:0]  target, run_sum;
  logic [VALUE_BITS-1:0]  rd_value;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic             scan_hit;

  assign req_i.ready  = (state_q == S_IDLE);
  assign in_fire      = req_i.valid && req_i.ready;
  assign is_full      = (occ_q == CntW'(DEPTH));
  assign is_empty_now = (occ_q == '0);
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign last_idx     = IdxW'(occ_q - CntW'(1));

  // target = floor(total * draw / 2^DRAW_BITS)
  wrpq_mul #(
    .A_BITS (TotW),
    .B_BITS (DRAW_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (total_q),
    .b_i     (req_i.random_draw),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign target    = mul_prod[DRAW_BITS +: TotW];
  assign rd_weight = rd_data_q[WEIGHT_BITS-1:0];
  assign rd_value  = rd_data_q[SlotW-1:WEIGHT_BITS];
  assign run_sum   = run_q + TotW'(rd_weight);
  // A zero total takes slot 0; the last held slot always ends the scan.
  assign scan_hit  = (run_sum > target) || (total_q == '0) || (dat_idx_q == last_idx);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (action_e'(req_i.action) == ACT_POP && !is_empty_now) begin
            state_d = S_MUL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_d = S_MOVE;
        end
      end
      S_MOVE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory and unit control.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = occ_q[IdxW-1:0];
    mem_wdata   = {req_i.item_value, req_i.weight};
    mem_raddr   = '0;
    mul_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && action_e'(req_i.action) == ACT_INSERT && !is_full) begin
          mem_we = 1'b1;
        end
        if (in_fire && action_e'(req_i.action) == ACT_POP && !is_empty_now) begin
          mul_start = 1'b1;
        end
      end
      S_MUL: mem_raddr = '0;
      S_SCAN: begin
        // On a hit, fetch the last slot so it can fill the gap.
        mem_raddr = scan_hit ? last_idx : dat_idx_q + 1'b1;
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = pick_idx_q;
        mem_wdata = rd_data_q;
      end
      S_DONE: mem_raddr = '0;
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_fire && action_e'(req_i.action) == ACT_INSERT && !is_full) begin
        occ_q   <= occ_q + 1'b1;
        total_q <= total_q + TotW'(req_i.weight);
      end else if (state_q == S_MOVE) begin
        occ_q   <= occ_q - 1'b1;
        total_q <= total_q - TotW'(pick_w_q);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_fire) begin
      res_popped_q <= '0;
      if (action_e'(req_i.action) == ACT_INSERT) begin
        res_status_q <= is_full ? ST_FULL : ST_OK;
      end else begin
        res_status_q <= is_empty_now ? ST_EMPTY : ST_OK;
      end
    end
    if (state_q == S_MUL && mul_done) begin
      run_q     <= '0;
      dat_idx_q <= '0;
    end
    if (state_q == S_SCAN) begin
      run_q     <= run_sum;
      dat_idx_q <= dat_idx_q + 1'b1;
      if (scan_hit) begin
        pick_idx_q <= dat_idx_q;
        pick_val_q <= rd_value;
        pick_w_q   <= rd_weight;
      end
    end
    if (state_q == S_MOVE) begin
      res_popped_q <= pick_val_q;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_popped_q <= res_popped_q;
      out_count_q  <= occ_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.popped_value = out_popped_q;
  assign rsp_o.entry_count  = out_count_q;
  assign rsp_o.is_empty     = (out_count_q == '0);

`ifndef SYNTHESIS
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_mul_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("multiplier finished outside the multiply phase");

  a_scan_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_MOVE) |-> occ_q != '0)
    else $error("scan on an empty table");

  a_pick_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE |-> CntW'(pick_idx_q) < occ_q)
    else $error("picked slot beyond occupancy");

  a_occ_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (occ_q == $past(occ_q) || occ_q == $past(occ_q) + 1'b1
              || occ_q + 1'b1 == $past(occ_q)))
    else $error("occupancy moved by more than one");
`endif

endmodule
